/* rtl/slmp_pkg.sv */
// Shared types and constants for the SLMP 3E binary response deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package slmp_pkg;

    // Frame layout, counted from the D0 byte of the header
    localparam int LENGTH_OFFSET = 7;
    localparam int OFF_W         = 4;
    localparam int WIN_BYTES     = 5;
    localparam int FILL_W        = 3;
    localparam int LEN_W         = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [OFF_W-1:0] OFF_HIT    = OFF_W'(6);
    localparam logic [OFF_W-1:0] OFF_LEN_LO = OFF_W'(LENGTH_OFFSET);
    localparam logic [OFF_W-1:0] OFF_LEN_HI = OFF_W'(LENGTH_OFFSET + 1);
    localparam logic [OFF_W-1:0] OFF_END_LO = OFF_W'(LENGTH_OFFSET + 2);
    localparam logic [OFF_W-1:0] OFF_END_HI = OFF_W'(LENGTH_OFFSET + 3);

    localparam logic [7:0] HDR_SUB_HI = 8'hD0;
    localparam logic [7:0] HDR_SUB_LO = 8'h00;
    localparam logic [7:0] HDR_NET    = 8'hFF;
    localparam logic [7:0] HDR_PLC    = 8'h03;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_ABNORMAL = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        status_t    status;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/slmp_front.sv */
// Front end: header search, header field capture and data byte counting.
// Produces at most one result per accepted byte. Uses slmp_pkg.
`default_nettype none

module slmp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output logic                  res_valid,
    output slmp_pkg::result_t     res
);
    import slmp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [8*WIN_BYTES-1:0] window_reg, window_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [OFF_W-1:0]       offset_reg, offset_next;
    logic [LEN_W-1:0]       length_reg, length_next;
    logic [7:0]             end_low_reg, end_low_next;

    logic hit;
    logic abnormal;
    logic len_le2;
    logic data_final;

    assign hit = (fill_reg >= FILL_W'(WIN_BYTES))
              && (window_reg[8*WIN_BYTES-1 -: 8] == HDR_SUB_HI)
              && (window_reg[8*WIN_BYTES-9 -: 8] == HDR_SUB_LO)
              && (window_reg[7:0] == HDR_NET)
              && (in_byte == HDR_PLC);
    assign abnormal   = (end_low_reg != 8'h00) || (in_byte != 8'h00);
    assign len_le2    = (length_reg <= LEN_W'(2));
    assign data_final = (length_reg <= LEN_W'(1));

    // next state
    always_comb begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        end_low_next = end_low_reg;
        if (in_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    offset_next = offset_reg + OFF_W'(1);
                    if (offset_reg == OFF_LEN_LO) begin
                        length_next = {8'h00, in_byte};
                    end else if (offset_reg == OFF_LEN_HI) begin
                        length_next = {in_byte, length_reg[7:0]};
                    end else if (offset_reg == OFF_END_LO) begin
                        end_low_next = in_byte;
                    end else if (offset_reg == OFF_END_HI) begin
                        if (abnormal || len_le2) begin
                            phase_next = PH_DRAIN;
                        end else begin
                            length_next = length_reg - LEN_W'(2);
                            phase_next  = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (data_final) begin
                        length_next = '0;
                        phase_next  = PH_DRAIN;
                    end else begin
                        length_next = length_reg - LEN_W'(1);
                    end
                end
                PH_DRAIN: begin
                end
                PH_SEARCH: begin
                    window_next = {window_reg[8*WIN_BYTES-9:0], in_byte};
                    if (fill_reg < FILL_W'(WIN_BYTES)) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (hit) begin
                        phase_next   = PH_HEADER;
                        offset_next  = OFF_HIT;
                        length_next  = '0;
                        end_low_next = '0;
                    end
                end
                default: begin
                end
            endcase
            // chunk end always restarts the search
            if (in_last) begin
                phase_next   = PH_SEARCH;
                window_next  = '0;
                fill_next    = '0;
                offset_next  = '0;
                length_next  = '0;
                end_low_next = '0;
            end
        end
    end

    // result
    always_comb begin
        res_valid     = 1'b0;
        res.data_byte = 8'h00;
        res.is_data   = 1'b0;
        res.status    = ST_OK;
        res.last      = 1'b1;
        if (in_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if ((offset_reg == OFF_END_HI) && abnormal) begin
                        res_valid  = 1'b1;
                        res.status = ST_ABNORMAL;
                    end else if ((offset_reg == OFF_END_HI) && len_le2) begin
                        res_valid   = 1'b1;
                        res.is_data = 1'b1;
                    end else if (in_last) begin
                        res_valid  = 1'b1;
                        res.status = ST_TRUNC;
                    end
                end
                PH_DATA: begin
                    res_valid     = 1'b1;
                    res.data_byte = in_byte;
                    res.is_data   = 1'b1;
                    if (!data_final) begin
                        res.status = in_last ? ST_TRUNC : ST_OK;
                        res.last   = in_last;
                    end
                end
                PH_DRAIN: begin
                end
                PH_SEARCH: begin
                    res_valid  = in_last;
                    res.status = hit ? ST_TRUNC : ST_NO_FRAME;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEARCH;
            window_reg  <= '0;
            fill_reg    <= '0;
            offset_reg  <= '0;
            length_reg  <= '0;
            end_low_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            end_low_reg <= end_low_next;
        end
    end

    a_chunk_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_last |=> phase_reg == PH_SEARCH && fill_reg == '0)
        else $error("chunk end did not restart the search");

    a_chunk_end_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_last && phase_reg != PH_DRAIN |-> res_valid && res.last)
        else $error("chunk end without a final result");

    a_drain_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DRAIN |-> !res_valid)
        else $error("result produced after the frame was answered");

    a_header_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> offset_reg >= OFF_HIT && offset_reg <= OFF_END_HI)
        else $error("header offset out of range");

endmodule

`default_nettype wire

/* rtl/slmp_queue.sv */
// Short result queue between the front end and the output stage.
// Register array with read and write pointers. Uses slmp_pkg.
`default_nettype none

module slmp_queue #(
    parameter int DEPTH = slmp_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire slmp_pkg::result_t push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output slmp_pkg::result_t     head_data
);
    import slmp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

`default_nettype wire

/* rtl/slmp_back.sv */
// Output stage: registers the queue head onto the result stream.
// Loads whenever the register is empty or being drained. Uses slmp_pkg.
`default_nettype none

module slmp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire slmp_pkg::result_t head_data,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,  // data_byte
    output logic [2:0]            m_tuser,  // [0] is_data, [2:1] status
    output logic                  m_tlast
);
    import slmp_pkg::*;

    logic    valid_reg, valid_next;
    result_t out_reg, out_next;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (pop) begin
            valid_next = 1'b1;
            out_next   = head_data;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds its value until the next load
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg.data_byte;
    assign m_tuser  = {out_reg.status, out_reg.is_data};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

/* rtl/slmp_response_deframer.sv */
// Top level of the SLMP 3E binary response deframer.
// Instantiates slmp_front, slmp_queue and slmp_back; uses slmp_pkg.
//
//  Channel  Dir  tdata          tuser                   tlast
//  s_       in   rx_byte[7:0]   -                       chunk_last
//  m_       out  data_byte[7:0] [0] is_data [2:1] status last
//
// One byte is accepted per cycle while the result queue has room; a byte's
// result, if any, is written into the queue and then loaded into the output
// register before it shows on m_tvalid.
// The front end updates its state once per accepted byte.
// s_tready drops only when QUEUE_DEPTH results wait behind a stalled m_ side.
// Synchronous active-low reset empties the queue and restarts the search.
`default_nettype none

module slmp_response_deframer #(
    parameter int QUEUE_DEPTH = slmp_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // data_byte
    output logic [2:0]       m_tuser,   // [0] is_data, [2:1] status
    output logic             m_tlast
);
    import slmp_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    logic    q_full;
    logic    head_valid;
    result_t head_data;
    logic    pop;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    slmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    slmp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    slmp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* tb/slmp_response_deframer_test.sv */
// Self-checking testbench for slmp_response_deframer: directed frame cases, then random chunks.
// Every accepted byte runs through a local deframer model; results are compared in order.
// Depends on slmp_pkg and the slmp_response_deframer RTL.
module slmp_response_deframer_test;
    import slmp_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 105;
    localparam int DIR_COUNT   = 31;

    localparam result_t R_NONE     = '0;
    localparam result_t R_NO_FRAME = '{8'h00, 1'b0, ST_NO_FRAME, 1'b1};
    localparam result_t R_TRUNC    = '{8'h00, 1'b0, ST_TRUNC, 1'b1};
    localparam result_t R_ABNORMAL = '{8'h00, 1'b0, ST_ABNORMAL, 1'b1};

    typedef struct packed {
        logic [7:0] rx;
        logic       fin;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        // lone byte, no header
        '{8'h00, 1'b1, 1'b1, R_NO_FRAME},
        // header completes on the chunk's final byte
        '{8'hD0, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'hFF, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'h03, 1'b1, 1'b1, R_TRUNC},
        // nonzero end code, high byte only
        '{8'hD0, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'h03, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b1, 1'b1, R_ABNORMAL},
        // length 3: one data byte, then a byte that is dropped
        '{8'hD0, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'h03, 1'b0, 1'b0, R_NONE},
        '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'h03, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b0, 1'b0, R_NONE},
        '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'hFF, 1'b0, 1'b0, R_NONE},
        '{8'hAA, 1'b1, 1'b0, R_NONE}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // rx_byte
    logic       s_tlast  = 1'b0;    // chunk_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // data_byte
    logic [2:0] m_tuser;            // [0] is_data, [2:1] status
    logic       m_tlast;

    // deframer model state
    logic [39:0] model_window;
    logic [2:0]  model_fill;
    phase_t      model_phase;
    logic [15:0] model_offset;
    logic [15:0] model_length;
    logic [7:0]  model_end_lo;

    result_t pending_results [$];
    result_t monitor_want;
    int      mismatches     = 0;
    int      cycle_count    = 0;
    int      items_sent     = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    int      hold_len       = 0;

    slmp_response_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    function automatic void restart_search();
        model_window = '0;
        model_fill   = '0;
        model_phase  = PH_SEARCH;
        model_offset = '0;
        model_length = '0;
        model_end_lo = '0;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic endc,
                                output bit got, output result_t r);
        bit done;
        bit hit;
        got  = 1'b0;
        done = 1'b0;
        r    = R_NONE;
        case (model_phase)
            PH_HEADER: begin
                if (model_offset == 16'(LENGTH_OFFSET)) begin
                    model_length = {8'h00, b};
                end else if (model_offset == 16'(LENGTH_OFFSET + 1)) begin
                    model_length = model_length | {b, 8'h00};
                end else if (model_offset == 16'(LENGTH_OFFSET + 2)) begin
                    model_end_lo = b;
                end else if (model_offset == 16'(LENGTH_OFFSET + 3)) begin
                    if (model_end_lo != 8'h00 || b != 8'h00) begin
                        r    = R_ABNORMAL;
                        got  = 1'b1;
                        done = 1'b1;
                    end else if (model_length <= 16'd2) begin
                        r    = '{8'h00, 1'b1, ST_OK, 1'b1};
                        got  = 1'b1;
                        done = 1'b1;
                    end else begin
                        model_length = model_length - 16'd2;
                        model_phase  = PH_DATA;
                    end
                end
                model_offset = model_offset + 16'd1;
                if (!done && endc) begin
                    r   = R_TRUNC;
                    got = 1'b1;
                end
            end
            PH_DATA: begin
                got = 1'b1;
                if (model_length <= 16'd1) begin
                    model_length = '0;
                    r    = '{b, 1'b1, ST_OK, 1'b1};
                    done = 1'b1;
                end else begin
                    model_length = model_length - 16'd1;
                    r = '{b, 1'b1, endc ? ST_TRUNC : ST_OK, endc};
                end
            end
            PH_DRAIN: begin
                // frame already answered: drop the rest of the chunk
            end
            default: begin
                hit = model_fill >= 3'd5 &&
                      model_window[39:32] == HDR_SUB_HI &&
                      model_window[31:24] == HDR_SUB_LO &&
                      model_window[7:0] == HDR_NET &&
                      b == HDR_PLC;
                model_window = {model_window[31:0], b};
                if (model_fill < 3'd5)
                    model_fill = model_fill + 3'd1;
                if (hit) begin
                    model_phase  = PH_HEADER;
                    model_offset = 16'd6;
                    model_length = '0;
                    model_end_lo = '0;
                    if (endc) begin
                        r   = R_TRUNC;
                        got = 1'b1;
                    end
                end else if (endc) begin
                    r   = R_NO_FRAME;
                    got = 1'b1;
                end
            end
        endcase
        if (done)
            model_phase = PH_DRAIN;
        if (endc)
            restart_search();
    endtask

    // Offer one byte, wait for the transfer, then record what it should produce.
    // A typed expectation overrides the model's result for that byte.
    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input bit typed, input result_t typed_want);
        bit      got;
        result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        deframe_byte(b, fin, got, r);
        if (typed)
            pending_results.push_back(typed_want);
        else if (got)
            pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic send_chunk();
        logic [7:0] bytes_q [$];
        int pick;
        int len;
        int ec;
        int ndata;
        int cut;
        pick = $urandom_range(99);
        if (pick < 75) begin
            repeat ($urandom_range(2)) bytes_q.push_back(8'($urandom));
            bytes_q.push_back(HDR_SUB_HI);
            bytes_q.push_back(HDR_SUB_LO);
            bytes_q.push_back(8'($urandom));
            bytes_q.push_back(8'($urandom));
            bytes_q.push_back(HDR_NET);
            bytes_q.push_back(HDR_PLC);
            bytes_q.push_back(8'($urandom));
            pick = $urandom_range(99);
            if (pick < 12)
                len = $urandom_range(2);
            else if (pick < 92)
                len = $urandom_range(14, 3);
            else
                len = $urandom_range(65535);
            bytes_q.push_back(8'(len));
            bytes_q.push_back(8'(len >> 8));
            ec = ($urandom_range(99) < 85) ? 0 : $urandom_range(65535, 1);
            bytes_q.push_back(8'(ec));
            bytes_q.push_back(8'(ec >> 8));
            // cap the payload; long lengths end up truncated by the chunk end
            ndata = (len > 2) ? len - 2 : 0;
            if (ndata > 24)
                ndata = 24;
            repeat (ndata) bytes_q.push_back(8'($urandom));
            repeat ($urandom_range(2)) bytes_q.push_back(8'($urandom));
            if ($urandom_range(99) < 10)
                bytes_q[$urandom_range(bytes_q.size() - 1)] = 8'($urandom);
            if ($urandom_range(99) < 15) begin
                cut = $urandom_range(bytes_q.size(), 1);
                while (bytes_q.size() > cut)
                    void'(bytes_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(10, 1)) bytes_q.push_back(8'($urandom));
            if ($urandom_range(1)) begin
                bytes_q.push_back(HDR_SUB_HI);
                bytes_q.push_back(HDR_SUB_LO);
            end
        end
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, R_NONE);
    endtask

    // Hold the sender until every expected result has arrived.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len  = hold_len - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: data_byte %0h tuser %0h tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                monitor_want = pending_results.pop_front();
                check_field("data_byte", monitor_want.data_byte, m_tdata);
                check_field("is_data", monitor_want.is_data, m_tuser[0]);
                check_field("status", int'(monitor_want.status), m_tuser[2:1]);
                check_field("last", monitor_want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int idle_pcts  [4];
        int stall_pcts [4];
        int goal;
        idle_pcts  = '{0, 59, 0, 15};
        stall_pcts = '{0, 0, 59, 15};
        restart_search();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_pcts[p];
            sink_stall_pct = stall_pcts[p];
            // long receiver hold-off while bytes keep coming: fill the block up
            if (p == 0)
                hold_len = 300;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                send_chunk();
            wait_idle();
        end

        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
